/* src/sticky_modifier_button_fsm_top_macros.svh */
// Assertion helpers for the RTL files that carry checks.
// Both forms sample on the rising edge of clk and are switched off while rst_n is low.
`ifndef STICKY_MODIFIER_BUTTON_FSM_TOP_MACROS_SVH
`define STICKY_MODIFIER_BUTTON_FSM_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/smb_pkg.sv */
`default_nettype none

package smb_pkg;

    // Button codes
    localparam logic [7:0] BTN_FN          = 8'd37;
    localparam logic [7:0] BTN_ALT         = 8'd64;
    localparam logic [7:0] BTN_SCROLL_UP   = 8'd185;
    localparam logic [7:0] BTN_SCROLL_DOWN = 8'd186;
    localparam logic [7:0] BTN_ROTATE      = 8'd161;
    localparam logic [7:0] BTN_BL_DOWN     = 8'd232;
    localparam logic [7:0] BTN_BL_UP       = 8'd233;

    // Register reset values
    localparam logic [15:0] STICKY_TIMEOUT_RESET = 16'd1400;
    localparam logic [15:0] MENU_TIMEOUT_RESET   = 16'd3000;
    localparam logic [15:0] ADJUST_TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] LONG_PRESS_RESET     = 16'd1000;

    typedef enum logic [1:0] {
        CFG_STICKY_TIMEOUT = 2'd0,
        CFG_MENU_TIMEOUT   = 2'd1,
        CFG_ADJUST_TIMEOUT = 2'd2,
        CFG_LONG_PRESS     = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_FN     = 3'd1,
        MODE_ALT    = 3'd2,
        MODE_CONF   = 3'd3,
        MODE_BRIGHT = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        SCROLL_PAGE  = 2'd0,
        SCROLL_SPACE = 2'd1,
        SCROLL_WHEEL = 2'd2
    } scroll_t;

    typedef enum logic [3:0] {
        KEY_NONE       = 4'd0,
        KEY_PGUP       = 4'd1,
        KEY_PGDN       = 4'd2,
        KEY_SPACE      = 4'd3,
        KEY_BKSP       = 4'd4,
        KEY_WHEEL_UP   = 4'd5,
        KEY_WHEEL_DOWN = 4'd6,
        KEY_LAUNCH1    = 4'd7,
        KEY_LAUNCH2    = 4'd8,
        KEY_LAUNCH3    = 4'd9,
        KEY_LAUNCH4    = 4'd10,
        KEY_LAUNCH_A   = 4'd11,
        KEY_LAUNCH_B   = 4'd12,
        KEY_LAUNCH_C   = 4'd13,
        KEY_SLEEP      = 4'd14,
        KEY_FORWARD    = 4'd15
    } key_t;

    typedef enum logic [2:0] {
        OSD_NONE   = 3'd0,
        OSD_HIDE   = 3'd1,
        OSD_FN     = 3'd2,
        OSD_ALT    = 3'd3,
        OSD_CONF   = 3'd4,
        OSD_SLIDER = 3'd5,
        OSD_SCROLL = 3'd6,
        OSD_ROT    = 3'd7
    } osd_t;

    typedef enum logic [1:0] {
        BL_NONE = 2'd0,
        BL_UP   = 2'd1,
        BL_DOWN = 2'd2,
        BL_OFF  = 2'd3
    } bl_t;

    typedef struct packed {
        logic [15:0] sticky_timeout_ms;
        logic [15:0] menu_timeout_ms;
        logic [15:0] adjust_timeout_ms;
        logic [15:0] long_press_ms;
    } smb_cfg_t;

    typedef struct packed {
        logic [7:0]  button_code;
        logic        pressed;
        logic [31:0] now_ms;
    } smb_event_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] mode_deadline;
        logic [7:0]  last_key_code;
        logic [31:0] last_key_time;
        scroll_t     scroll_sel;
        logic        rotation_lock;
    } smb_state_t;

    typedef struct packed {
        key_t    key_action;
        logic [7:0] fwd_code;
        logic    fwd_pressed;
        osd_t    osd_action;
        bl_t     backlight_action;
        mode_t   mode;
        scroll_t scroll_sel;
        logic    rotation_lock;
    } smb_result_t;

    // True when a lies strictly after b within half the 32-bit wrap.
    function automatic logic is_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage

`default_nettype wire

/* src/smb_ifs.sv */
`default_nettype none

interface smb_event_if;
    logic        valid;
    logic        ready;
    logic [7:0]  button_code;
    logic        pressed;
    logic [31:0] now_ms;

    modport source (output valid, button_code, pressed, now_ms, input ready);
    modport sink   (input valid, button_code, pressed, now_ms, output ready);
endinterface

interface smb_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] key_action;
    logic [7:0] fwd_code;
    logic       fwd_pressed;
    logic [2:0] osd_action;
    logic [1:0] backlight_action;
    logic [2:0] mode_out;
    logic [1:0] scroll_mode_out;
    logic       rotation_lock_out;

    modport source (
        output valid, key_action, fwd_code, fwd_pressed, osd_action, backlight_action,
               mode_out, scroll_mode_out, rotation_lock_out,
        input  ready
    );
    modport sink (
        input  valid, key_action, fwd_code, fwd_pressed, osd_action, backlight_action,
               mode_out, scroll_mode_out, rotation_lock_out,
        output ready
    );
endinterface

`default_nettype wire

/* src/smb_cfg_regs.sv */
`default_nettype none

// Timeout registers, written through a simple indexed write port.
module smb_cfg_regs
    import smb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    output smb_cfg_t         cfg
);

    smb_cfg_t cfg_reg;
    smb_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_STICKY_TIMEOUT: cfg_next.sticky_timeout_ms = cfg_wdata;
                CFG_MENU_TIMEOUT:   cfg_next.menu_timeout_ms   = cfg_wdata;
                CFG_ADJUST_TIMEOUT: cfg_next.adjust_timeout_ms = cfg_wdata;
                CFG_LONG_PRESS:     cfg_next.long_press_ms     = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sticky_timeout_ms <= STICKY_TIMEOUT_RESET;
            cfg_reg.menu_timeout_ms   <= MENU_TIMEOUT_RESET;
            cfg_reg.adjust_timeout_ms <= ADJUST_TIMEOUT_RESET;
            cfg_reg.long_press_ms     <= LONG_PRESS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/smb_step.sv */
`default_nettype none

// Next state and result for one button event, all in one combinational pass.
module smb_step
    import smb_pkg::*;
(
    input  wire smb_state_t  st,
    input  wire smb_cfg_t    cfg,
    input  wire smb_event_t  ev,
    output smb_state_t  st_next,
    output smb_result_t rs
);

    logic        acting;
    logic        up;
    logic        long_fn;
    logic        long_alt;
    logic        upd_deadline;
    logic [15:0] extend_ms;
    logic [31:0] lp_limit;
    mode_t       mode_eff;

    assign acting = (ev.button_code == BTN_FN) || (ev.button_code == BTN_ALT)
                 || (ev.button_code == BTN_SCROLL_UP) || (ev.button_code == BTN_SCROLL_DOWN)
                 || (ev.button_code == BTN_ROTATE);
    assign up       = (ev.button_code == BTN_SCROLL_UP);
    assign lp_limit = st.last_key_time + {16'd0, cfg.long_press_ms};
    assign long_fn  = (st.last_key_code == BTN_FN) && is_after(ev.now_ms, lp_limit);
    assign long_alt = (st.last_key_code == BTN_ALT) && is_after(ev.now_ms, lp_limit);
    // A press that comes after the deadline drops back to normal mode first.
    assign mode_eff = (ev.pressed && is_after(ev.now_ms, st.mode_deadline)) ? MODE_NORMAL
                                                                             : st.mode;

    always_comb
    begin
        st_next      = st;
        st_next.mode = mode_eff;
        upd_deadline = 1'b0;
        extend_ms    = cfg.sticky_timeout_ms;
        rs.key_action       = KEY_NONE;
        rs.fwd_code         = 8'd0;
        rs.fwd_pressed      = 1'b0;
        rs.osd_action       = OSD_NONE;
        rs.backlight_action = BL_NONE;

        if (acting && ev.pressed)
        begin
            st_next.last_key_code = ev.button_code;
            st_next.last_key_time = ev.now_ms;
        end
        else
        begin
            st_next.last_key_code = 8'd0;
            st_next.last_key_time = 32'd0;
            if (ev.button_code == BTN_FN)
            begin
                if (mode_eff == MODE_NORMAL)
                begin
                    st_next.mode  = MODE_FN;
                    upd_deadline  = 1'b1;
                    rs.osd_action = OSD_FN;
                end
                else if (mode_eff == MODE_ALT && long_fn)
                begin
                    st_next.mode  = MODE_CONF;
                    upd_deadline  = 1'b1;
                    extend_ms     = cfg.menu_timeout_ms;
                    rs.osd_action = OSD_CONF;
                end
                else
                begin
                    if (mode_eff == MODE_ALT)
                    begin
                        rs.key_action = KEY_LAUNCH4;
                    end
                    st_next.mode  = MODE_NORMAL;
                    rs.osd_action = OSD_HIDE;
                end
            end
            else if (ev.button_code == BTN_ALT)
            begin
                if (mode_eff == MODE_NORMAL)
                begin
                    if (long_alt)
                    begin
                        rs.key_action = KEY_SLEEP;
                        rs.osd_action = OSD_HIDE;
                    end
                    else
                    begin
                        st_next.mode  = MODE_ALT;
                        upd_deadline  = 1'b1;
                        rs.osd_action = OSD_ALT;
                    end
                end
                else if (mode_eff == MODE_FN)
                begin
                    st_next.mode  = MODE_BRIGHT;
                    upd_deadline  = 1'b1;
                    extend_ms     = cfg.menu_timeout_ms;
                    rs.osd_action = OSD_SLIDER;
                end
                else
                begin
                    st_next.mode  = MODE_NORMAL;
                    rs.osd_action = OSD_HIDE;
                end
            end
            else if (ev.button_code == BTN_SCROLL_UP || ev.button_code == BTN_SCROLL_DOWN)
            begin
                unique case (mode_eff)
                    MODE_NORMAL:
                    begin
                        unique case (st.scroll_sel)
                            SCROLL_PAGE:  rs.key_action = up ? KEY_PGUP : KEY_PGDN;
                            SCROLL_SPACE: rs.key_action = up ? KEY_SPACE : KEY_BKSP;
                            default:      rs.key_action = up ? KEY_WHEEL_UP : KEY_WHEEL_DOWN;
                        endcase
                    end
                    MODE_FN:
                    begin
                        st_next.mode  = MODE_NORMAL;
                        rs.key_action = up ? KEY_LAUNCH_B : KEY_LAUNCH_A;
                        rs.osd_action = OSD_HIDE;
                    end
                    MODE_ALT:
                    begin
                        st_next.mode  = MODE_NORMAL;
                        rs.key_action = up ? KEY_LAUNCH2 : KEY_LAUNCH1;
                        rs.osd_action = OSD_HIDE;
                    end
                    MODE_CONF:
                    begin
                        // The scroll mode steps round its three settings.
                        if (up)
                        begin
                            unique case (st.scroll_sel)
                                SCROLL_PAGE:  st_next.scroll_sel = SCROLL_WHEEL;
                                SCROLL_SPACE: st_next.scroll_sel = SCROLL_PAGE;
                                default:      st_next.scroll_sel = SCROLL_SPACE;
                            endcase
                        end
                        else
                        begin
                            unique case (st.scroll_sel)
                                SCROLL_PAGE:  st_next.scroll_sel = SCROLL_SPACE;
                                SCROLL_SPACE: st_next.scroll_sel = SCROLL_WHEEL;
                                default:      st_next.scroll_sel = SCROLL_PAGE;
                            endcase
                        end
                        rs.osd_action = OSD_SCROLL;
                        upd_deadline  = 1'b1;
                        extend_ms     = cfg.adjust_timeout_ms;
                    end
                    default:
                    begin
                        rs.backlight_action = up ? BL_UP : BL_DOWN;
                        rs.osd_action       = OSD_SLIDER;
                        upd_deadline        = 1'b1;
                        extend_ms           = cfg.adjust_timeout_ms;
                    end
                endcase
            end
            else if (ev.button_code == BTN_ROTATE)
            begin
                unique case (mode_eff)
                    MODE_FN:
                    begin
                        st_next.mode  = MODE_NORMAL;
                        rs.key_action = KEY_LAUNCH_C;
                        rs.osd_action = OSD_HIDE;
                    end
                    MODE_ALT:
                    begin
                        st_next.mode  = MODE_NORMAL;
                        rs.key_action = KEY_LAUNCH3;
                        rs.osd_action = OSD_HIDE;
                    end
                    MODE_CONF:
                    begin
                        st_next.rotation_lock = !st.rotation_lock;
                        rs.osd_action         = OSD_ROT;
                    end
                    MODE_BRIGHT:
                    begin
                        rs.backlight_action = BL_OFF;
                    end
                    default:
                    begin
                        rs.key_action = KEY_NONE;
                    end
                endcase
            end
            else if (ev.button_code == BTN_BL_DOWN || ev.button_code == BTN_BL_UP)
            begin
                if (!ev.pressed)
                begin
                    rs.backlight_action = (ev.button_code == BTN_BL_UP) ? BL_UP : BL_DOWN;
                    rs.osd_action       = OSD_SLIDER;
                end
            end
            else
            begin
                st_next.mode   = MODE_NORMAL;
                rs.osd_action  = OSD_HIDE;
                rs.key_action  = KEY_FORWARD;
                rs.fwd_code    = ev.button_code;
                rs.fwd_pressed = ev.pressed;
            end
        end

        if (upd_deadline)
        begin
            st_next.mode_deadline = ev.now_ms + {16'd0, extend_ms};
        end

        rs.mode          = st_next.mode;
        rs.scroll_sel    = st_next.scroll_sel;
        rs.rotation_lock = st_next.rotation_lock;
    end

endmodule

`default_nettype wire

/* src/sticky_modifier_button_fsm_top.sv */
// Path: an event beat is taken into the event register, then moves into the result
// register once that is empty or its beat is taken by the sink.
// Throughput: one event per cycle while the sink takes every result beat.
// Reset (rst_n low, asynchronous): normal mode, deadlines and last key cleared,
// wheel scroll mode, rotation unlocked, timeout registers back to their defaults.
`default_nettype none

`include "sticky_modifier_button_fsm_top_macros.svh"

module sticky_modifier_button_fsm_top
    import smb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    smb_event_if.sink        evt,
    smb_result_if.source     res,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    // Timeout registers live in their own block; the user must change them only
    // while the pipeline is empty, not enforced here; step logic reads them directly.
    smb_cfg_t cfg;

    smb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Event register. An event beat is taken whenever the register is empty or
    // its content moves on in the same cycle, so the event register can still
    // take one beat while a full result register waits for the sink.
    logic        ev_vld_reg;
    smb_event_t  ev_reg;
    logic        res_vld_reg;
    smb_result_t res_reg;
    smb_state_t  st_reg;
    smb_state_t  st_next;
    smb_result_t rs_next;
    logic        fire;
    logic        evt_take;

    assign fire     = ev_vld_reg && (!res_vld_reg || res.ready);
    assign evt.ready = !ev_vld_reg || fire;
    assign evt_take = evt.valid && evt.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_vld_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            ev_vld_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            ev_reg.button_code <= evt.button_code;
            ev_reg.pressed     <= evt.pressed;
            ev_reg.now_ms      <= evt.now_ms;
        end
    end

    // The mode machine: all decisions come from the step logic in one pass,
    // and the state is committed at the same edge as the result it goes with.
    // Back-to-back events therefore always see the state left by the one before.
    smb_step u_step (
        .st      (st_reg),
        .cfg     (cfg),
        .ev      (ev_reg),
        .st_next (st_next),
        .rs      (rs_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode          <= MODE_NORMAL;
            st_reg.mode_deadline <= 32'd0;
            st_reg.last_key_code <= 8'd0;
            st_reg.last_key_time <= 32'd0;
            st_reg.scroll_sel    <= SCROLL_WHEEL;
            st_reg.rotation_lock <= 1'b0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    // Result register: holds its beat until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= rs_next;
        end
    end

    assign res.valid             = res_vld_reg;
    assign res.key_action        = res_reg.key_action;
    assign res.fwd_code          = res_reg.fwd_code;
    assign res.fwd_pressed       = res_reg.fwd_pressed;
    assign res.osd_action        = res_reg.osd_action;
    assign res.backlight_action  = res_reg.backlight_action;
    assign res.mode_out          = res_reg.mode;
    assign res.scroll_mode_out   = res_reg.scroll_sel;
    assign res.rotation_lock_out = res_reg.rotation_lock;

    // Checks on the pipeline control and on the mode machine.
    `SMB_ASSERT_NEXT(a_fire_gives_result, fire, res_vld_reg,
        "processed event did not produce a result beat")
    `SMB_ASSERT_NEXT(a_state_holds_idle, !fire, $stable(st_reg),
        "state changed without an event being processed")
    `SMB_ASSERT_SAME(a_forward_is_normal,
        res_vld_reg && res_reg.key_action == KEY_FORWARD, res_reg.mode == MODE_NORMAL,
        "forwarded key left the block outside normal mode")
    `SMB_ASSERT_NEXT(a_last_key_cleared,
        fire && !(ev_reg.pressed && st_next.last_key_code == ev_reg.button_code
                  && ev_reg.button_code != 8'd0),
        st_reg.last_key_code == 8'd0 && st_reg.last_key_time == 32'd0,
        "last key record not cleared after a non-recording event")

endmodule

`default_nettype wire
